/* src/ats_pkg.sv */
// ----------------------------------------------------------------------------
// ats_pkg
// Shared widths, constants and fixed-point settings for the arctanh series
// evaluator and its channel interfaces.
// ----------------------------------------------------------------------------
package ats_pkg;

	// Fixed-point format of the argument, the odd powers and the terms.
	localparam int FRAC_BITS = 30;

	// Field widths of the channels.
	localparam int X_W     = 31;
	localparam int MAG_W   = 30;
	localparam int RES_W   = 34;
	localparam int TERMS_W = 7;
	localparam int PREC_W  = 30;
	localparam int PROD_W  = 2 * MAG_W;

	// Reset value of the precision register.
	localparam logic [PREC_W-1:0] PREC_RESET = PREC_W'(1074);

	// Largest magnitude below one; larger arguments are clamped to it.
	localparam logic [X_W-1:0] MAG_ONE_MINUS = X_W'((64'd1 << FRAC_BITS) - 64'd1);

	// Half an LSB of a product, for round half up.
	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(64'd1 << (FRAC_BITS - 1));

	// Saturation limit of the magnitude sum.
	localparam logic [RES_W-1:0] SUM_MAX = RES_W'((64'd1 << (RES_W - 1)) - 64'd1);

endpackage : ats_pkg

/* src/ats_channels.sv */
// ----------------------------------------------------------------------------
// ats_channels
// Valid/ready channel interfaces for the argument, the result and the
// precision register write port.
// ----------------------------------------------------------------------------
interface ats_x_if;
	import ats_pkg::*;

	logic                  valid;
	logic                  ready;
	logic signed [X_W-1:0] x_value;

	modport source (output valid, output x_value, input ready);
	modport sink   (input valid, input x_value, output ready);
endinterface : ats_x_if

interface ats_res_if;
	import ats_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [RES_W-1:0] result;
	logic [TERMS_W-1:0]      terms_used;
	logic                    cap_hit;

	modport source (output valid, output result, output terms_used, output cap_hit,
		input ready);
	modport sink   (input valid, input result, input terms_used, input cap_hit,
		output ready);
endinterface : ats_res_if

interface ats_cfg_if;
	import ats_pkg::*;

	logic              valid;
	logic              ready;
	logic [PREC_W-1:0] precision;

	modport source (output valid, output precision, input ready);
	modport sink   (input valid, input precision, output ready);
endinterface : ats_cfg_if

/* src/arctanh_series_evaluator.sv */
// ----------------------------------------------------------------------------
// arctanh_series_evaluator
// Sums the Maclaurin series of arctanh for one Q1.30 argument at a time and
// returns a Q3.30 sum, the number of terms added and a term-cap flag.
// ----------------------------------------------------------------------------
// One argument is processed at a time. After the argument transfer the block
// squares |x|, then for every series term it runs a restoring divider (one
// quotient bit per cycle) and then accumulates and tests the term; each
// further term first uses the shared multiplier to update the odd power. The
// default cap is 64 terms. The argument channel is ready only while the
// sequencer is idle. The result sits in an output register, so the next
// argument can be taken while an earlier result still waits for its
// transfer. The precision register is written through its own channel,
// which is always ready; it should only be written while the block is
// idle.
module arctanh_series_evaluator #(
	parameter int MAX_TERMS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	ats_x_if.sink        x_chan,
	ats_res_if.source    res_chan,
	ats_cfg_if.sink      cfg_chan
);
	import ats_pkg::*;

	// Width of the term counter (must hold MAX_TERMS) and of the odd divisor.
	localparam int NW  = $clog2(MAX_TERMS + 1);
	localparam int DW  = NW + 1;
	localparam int BCW = $clog2(MAG_W);

	// Sequencer states.
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SQUARE = 3'd1;
	localparam logic [2:0] S_DIV    = 3'd2;
	localparam logic [2:0] S_ACC    = 3'd3;
	localparam logic [2:0] S_MUL    = 3'd4;
	localparam logic [2:0] S_FINISH = 3'd5;

	logic [2:0]         state_q;
	logic               neg_q;
	logic [MAG_W-1:0]   pw_q;      // current odd power of |x|
	logic [MAG_W-1:0]   x2_q;      // rounded square of |x|
	logic [NW-1:0]      n_q;       // terms added so far
	logic [RES_W-1:0]   sum_q;     // magnitude of the partial sum
	logic [DW-1:0]      rem_q;     // divider remainder
	logic [MAG_W-1:0]   quo_q;     // dividend shifting out, quotient shifting in
	logic [BCW-1:0]     bit_q;     // divider bit counter
	logic               done_q;    // sum ended on the precision test

	logic                    res_valid_q;
	logic signed [RES_W-1:0] res_result_q;
	logic [TERMS_W-1:0]      res_terms_q;
	logic                    res_cap_q;
	logic [PREC_W-1:0]       precision_q;

	// ------------------------------------------------------------------
	// Argument magnitude, clamped just below one.
	// ------------------------------------------------------------------
	logic [X_W-1:0]   mag_full;
	logic [MAG_W-1:0] mag_sat;

	always_comb begin
		mag_full = x_chan.x_value[X_W-1] ? (X_W'(0) - x_chan.x_value) : x_chan.x_value;
		if (mag_full > MAG_ONE_MINUS) begin
			mag_sat = MAG_ONE_MINUS[MAG_W-1:0];
		end else begin
			mag_sat = mag_full[MAG_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Shared multiplier: squares |x| once, then multiplies the odd power by
	// x squared for every further term. Rounded half up back to unsigned Q0.30.
	// ------------------------------------------------------------------
	logic [MAG_W-1:0]  mul_b;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] prod_rnd;
	logic [MAG_W-1:0]  mul_res;

	assign mul_b    = (state_q == S_SQUARE) ? pw_q : x2_q;
	assign prod     = PROD_W'(pw_q) * PROD_W'(mul_b);
	assign prod_rnd = prod + ROUND_HALF;
	assign mul_res  = prod_rnd[FRAC_BITS +: MAG_W];

	// ------------------------------------------------------------------
	// Restoring divider step: one quotient bit per cycle by 2n+1.
	// ------------------------------------------------------------------
	logic [DW-1:0] divisor;
	logic [DW:0]   div_shift;
	logic [DW:0]   div_trial;
	logic          div_bit;

	assign divisor   = {n_q, 1'b1};
	assign div_shift = {rem_q, quo_q[MAG_W-1]};
	assign div_trial = div_shift - {1'b0, divisor};
	assign div_bit   = ~div_trial[DW];

	// ------------------------------------------------------------------
	// Accumulate with saturation, and the stop tests.
	// ------------------------------------------------------------------
	logic [RES_W-1:0] sum_add;
	logic [RES_W-1:0] sum_next;
	logic [NW-1:0]    n_next;
	logic             below_prec;
	logic             at_cap;

	always_comb begin
		sum_add = sum_q + RES_W'(quo_q);
		if (sum_add > SUM_MAX) begin
			sum_next = SUM_MAX;
		end else begin
			sum_next = sum_add;
		end
		n_next     = n_q + NW'(1);
		below_prec = (quo_q < precision_q);
		at_cap     = (n_next == NW'(MAX_TERMS));
	end

	// The result register can be loaded when it is empty or being drained.
	logic out_free;
	assign out_free = !res_valid_q || res_chan.ready;

	// ------------------------------------------------------------------
	// Sequencer.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (x_chan.valid) begin
						state_q <= S_SQUARE;
					end
				end
				S_SQUARE: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (bit_q == '0) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if (below_prec || at_cap) begin
						state_q <= S_FINISH;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_DIV;
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers; they need no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				neg_q <= x_chan.x_value[X_W-1];
				pw_q  <= mag_sat;
				n_q   <= '0;
				sum_q <= '0;
			end
			S_SQUARE: begin
				x2_q  <= mul_res;
				quo_q <= pw_q;
				rem_q <= '0;
				bit_q <= BCW'(MAG_W - 1);
			end
			S_DIV: begin
				quo_q <= {quo_q[MAG_W-2:0], div_bit};
				rem_q <= div_bit ? div_trial[DW-1:0] : div_shift[DW-1:0];
				bit_q <= bit_q - BCW'(1);
			end
			S_ACC: begin
				sum_q  <= sum_next;
				n_q    <= n_next;
				done_q <= below_prec;
			end
			S_MUL: begin
				pw_q  <= mul_res;
				quo_q <= mul_res;
				rem_q <= '0;
				bit_q <= BCW'(MAG_W - 1);
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Result register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && res_chan.ready) begin
				res_valid_q <= 1'b0;
			end
			if (state_q == S_FINISH && out_free) begin
				res_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FINISH && out_free) begin
			res_result_q <= $signed(neg_q ? (RES_W'(0) - sum_q) : sum_q);
			res_terms_q  <= TERMS_W'(n_q);
			res_cap_q    <= !done_q;
		end
	end

	// ------------------------------------------------------------------
	// Precision register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			precision_q <= PREC_RESET;
		end else if (cfg_chan.valid) begin
			precision_q <= cfg_chan.precision;
		end
	end

	assign cfg_chan.ready      = 1'b1;
	assign x_chan.ready        = (state_q == S_IDLE);
	assign res_chan.valid      = res_valid_q;
	assign res_chan.result     = res_result_q;
	assign res_chan.terms_used = res_terms_q;
	assign res_chan.cap_hit    = res_cap_q;

endmodule : arctanh_series_evaluator

/* src/ats_checker.sv */
// ----------------------------------------------------------------------------
// ats_checker
// Port-level checks for the arctanh series evaluator, bound to its top level.
// ----------------------------------------------------------------------------
module ats_checker #(
	parameter int MAX_TERMS = 64
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           x_valid,
	input logic                           x_ready,
	input logic                           res_valid,
	input logic                           res_ready,
	input logic signed [ats_pkg::RES_W-1:0] res_result,
	input logic [ats_pkg::TERMS_W-1:0]    res_terms_used,
	input logic                           res_cap_hit
);
	import ats_pkg::*;

	// A stalled result holds still until its transfer.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_result)
			&& $stable(res_terms_used) && $stable(res_cap_hit))
		else $error("result changed while stalled");

	// Every result counts at least one term.
	a_terms_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_terms_used != '0)
		else $error("result with zero terms");

	// The cap flag only appears when the full number of terms was added.
	a_cap_terms: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_cap_hit |-> res_terms_used == TERMS_W'(MAX_TERMS))
		else $error("cap flag without the full term count");

	// The evaluator is busy in the cycle after it takes an argument.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		x_valid && x_ready |=> !x_ready)
		else $error("argument channel ready right after a transfer");

endmodule : ats_checker

bind arctanh_series_evaluator ats_checker #(.MAX_TERMS(MAX_TERMS)) u_ats_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.x_valid        (x_chan.valid),
	.x_ready        (x_chan.ready),
	.res_valid      (res_chan.valid),
	.res_ready      (res_chan.ready),
	.res_result     (res_chan.result),
	.res_terms_used (res_chan.terms_used),
	.res_cap_hit    (res_chan.cap_hit)
);
